// File: sv/rsrc_pkg.sv
`timescale 1ns / 1ps

package rsrc_pkg;

    // Fields of one input transfer.
    typedef struct packed {
        logic               command;
        logic [31:0]        sample_time;
        logic signed [15:0] temperature;
    } sample_t;

    // Fields of one result transfer.
    typedef struct packed {
        logic               relay_on;
        logic [2:0]         phase;
        logic signed [15:0] heat_rate;
    } result_t;

    // Input command codes.
    typedef enum logic {
        CMD_START  = 1'b0,
        CMD_SAMPLE = 1'b1
    } command_t;

    // Register indexes on the configuration port.
    typedef enum logic [2:0] {
        REG_RATE_LIMIT  = 3'd0,
        REG_LEVEL_ONE   = 3'd1,
        REG_LEVEL_TWO   = 3'd2,
        REG_LEVEL_THREE = 3'd3,
        REG_FINAL_LEVEL = 3'd4,
        REG_HOLD_ONE    = 3'd5,
        REG_HOLD_TWO    = 3'd6,
        REG_HOLD_THREE  = 3'd7
    } reg_index_t;

    // Profile phases.
    typedef enum logic [2:0] {
        PH_RAMP_ONE   = 3'd0,
        PH_HOLD_ONE   = 3'd1,
        PH_RAMP_TWO   = 3'd2,
        PH_HOLD_TWO   = 3'd3,
        PH_RAMP_THREE = 3'd4,
        PH_HOLD_THREE = 3'd5,
        PH_COOL       = 3'd6,
        PH_DONE       = 3'd7
    } phase_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_RATE,
        ST_REG,
        ST_EMIT
    } seq_state_t;

    localparam logic [15:0] MS_PER_MINUTE = 16'd60000;
    localparam int unsigned QUOT_BITS = 32;

    // Rate saturation bounds.
    localparam logic [31:0] RATE_POS_MAX = 32'd32767;
    localparam logic [31:0] RATE_NEG_MAX = 32'd32768;

    // Register values after reset.
    localparam logic [14:0] RESET_RATE_LIMIT  = 15'd32;
    localparam logic [15:0] RESET_LEVEL_ONE   = 16'd1120;
    localparam logic [15:0] RESET_LEVEL_TWO   = 16'd2240;
    localparam logic [15:0] RESET_LEVEL_THREE = 16'd2880;
    localparam logic [15:0] RESET_FINAL_LEVEL = 16'd320;
    localparam logic [31:0] RESET_HOLD_ONE    = 32'd3600000;
    localparam logic [31:0] RESET_HOLD_TWO    = 32'd7200000;
    localparam logic [31:0] RESET_HOLD_THREE  = 32'd10800000;

endpackage

// File: sv/ramp_soak_relay_controller.sv
`timescale 1ns / 1ps

// Ramp/soak heater relay controller. A start transfer loads the reference time and
// temperature and returns the current relay, phase and rate unchanged. A sample
// transfer updates the heating rate (temperature change times 60000 over the elapsed
// milliseconds, saturated to 16 bits) and steps the profile: ramp to level one, hold,
// ramp to level two, hold, ramp to level three, hold, cool down, finished (phase 7).
// Most of a sample's work is a restoring divider that produces one quotient bit per
// cycle; a sample with the same timestamp as the reference skips the divider. The block
// takes one item at a time and holds sample_stall high while it works; a finished
// result waits in the output register, so the next item can be accepted before it is
// taken. The user must write the configuration registers through the APB port only
// while the block is idle; the block does not enforce this.
module ramp_soak_relay_controller #(
    parameter int TIME_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_stall,
    input  rsrc_pkg::sample_t sample,
    output logic              result_valid,
    input  logic              result_stall,
    output rsrc_pkg::result_t result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int RemBits = TIME_BITS + 1;
    localparam int CountBits = $clog2(rsrc_pkg::QUOT_BITS);

    // Configuration registers.
    logic [14:0]        rate_limit_reg;
    logic signed [15:0] level_one_reg;
    logic signed [15:0] level_two_reg;
    logic signed [15:0] level_three_reg;
    logic signed [15:0] final_level_reg;
    logic [31:0]        hold_one_reg;
    logic [31:0]        hold_two_reg;
    logic [31:0]        hold_three_reg;

    // Controller state.
    logic [TIME_BITS-1:0] last_time_reg;
    logic signed [15:0]   last_temp_reg;
    logic signed [15:0]   rate_reg;
    logic [2:0]           phase_reg;
    logic [TIME_BITS-1:0] hold_start_reg;
    logic                 relay_reg;

    // Item and divider registers.
    rsrc_pkg::seq_state_t state_reg;
    rsrc_pkg::seq_state_t state_next;
    logic [TIME_BITS-1:0] time_reg;
    logic signed [15:0]   temp_reg;
    logic [TIME_BITS-1:0] delta_reg;
    logic                 neg_reg;
    logic [31:0]          mag_reg;
    logic [31:0]          quot_reg;
    logic [RemBits-1:0]   rem_reg;
    logic [CountBits-1:0] count_reg;

    // Output register.
    logic                 result_valid_reg;
    rsrc_pkg::result_t    result_reg;

    logic                 sample_take;
    logic                 cfg_write;
    rsrc_pkg::reg_index_t cfg_index;
    logic                 out_free;

    logic [TIME_BITS-1:0] delta_now;
    logic signed [16:0]   temp_diff;
    logic [15:0]          diff_mag;
    logic [RemBits-1:0]   rem_shift;
    logic                 rem_fits;
    logic [15:0]          rate_sat;

    logic signed [15:0]   level_sel;
    logic [TIME_BITS-1:0] hold_sel;
    logic [TIME_BITS-1:0] hold_end;
    logic                 phase_adv;
    logic                 hold_mark;
    logic                 relay_new;

    assign sample_take = sample_valid && !sample_stall;
    assign cfg_write   = psel && penable && pwrite;
    assign cfg_index   = rsrc_pkg::reg_index_t'(paddr[4:2]);
    assign out_free    = !result_valid_reg || !result_stall;
    assign pready      = 1'b1;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_limit_reg  <= rsrc_pkg::RESET_RATE_LIMIT;
            level_one_reg   <= rsrc_pkg::RESET_LEVEL_ONE;
            level_two_reg   <= rsrc_pkg::RESET_LEVEL_TWO;
            level_three_reg <= rsrc_pkg::RESET_LEVEL_THREE;
            final_level_reg <= rsrc_pkg::RESET_FINAL_LEVEL;
            hold_one_reg    <= rsrc_pkg::RESET_HOLD_ONE;
            hold_two_reg    <= rsrc_pkg::RESET_HOLD_TWO;
            hold_three_reg  <= rsrc_pkg::RESET_HOLD_THREE;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                rsrc_pkg::REG_RATE_LIMIT:  rate_limit_reg  <= pwdata[14:0];
                rsrc_pkg::REG_LEVEL_ONE:   level_one_reg   <= pwdata[15:0];
                rsrc_pkg::REG_LEVEL_TWO:   level_two_reg   <= pwdata[15:0];
                rsrc_pkg::REG_LEVEL_THREE: level_three_reg <= pwdata[15:0];
                rsrc_pkg::REG_FINAL_LEVEL: final_level_reg <= pwdata[15:0];
                rsrc_pkg::REG_HOLD_ONE:    hold_one_reg    <= pwdata;
                rsrc_pkg::REG_HOLD_TWO:    hold_two_reg    <= pwdata;
                rsrc_pkg::REG_HOLD_THREE:  hold_three_reg  <= pwdata;
                default:                   rate_limit_reg  <= rate_limit_reg;
            endcase
        end
    end

    // Configuration register reads.
    always_comb
    begin
        unique case (cfg_index)
            rsrc_pkg::REG_RATE_LIMIT:  prdata = {17'd0, rate_limit_reg};
            rsrc_pkg::REG_LEVEL_ONE:   prdata = {16'd0, level_one_reg};
            rsrc_pkg::REG_LEVEL_TWO:   prdata = {16'd0, level_two_reg};
            rsrc_pkg::REG_LEVEL_THREE: prdata = {16'd0, level_three_reg};
            rsrc_pkg::REG_FINAL_LEVEL: prdata = {16'd0, final_level_reg};
            rsrc_pkg::REG_HOLD_ONE:    prdata = hold_one_reg;
            rsrc_pkg::REG_HOLD_TWO:    prdata = hold_two_reg;
            rsrc_pkg::REG_HOLD_THREE:  prdata = hold_three_reg;
            default:                   prdata = 32'd0;
        endcase
    end

    // Rate arithmetic: difference, magnitude, one divider step and saturation.
    always_comb
    begin
        delta_now = time_reg - last_time_reg;
        temp_diff = {temp_reg[15], temp_reg} - {last_temp_reg[15], last_temp_reg};
        diff_mag  = temp_diff[16] ? 16'(-temp_diff) : temp_diff[15:0];
        rem_shift = {rem_reg[RemBits-2:0], mag_reg[31]};
        rem_fits  = rem_shift >= {1'b0, delta_reg};
        if (neg_reg)
        begin
            rate_sat = (quot_reg > rsrc_pkg::RATE_NEG_MAX) ? 16'h8000 : 16'(~quot_reg[15:0] + 16'd1);
        end
        else
        begin
            rate_sat = (quot_reg > rsrc_pkg::RATE_POS_MAX) ? 16'h7FFF : quot_reg[15:0];
        end
    end

    // Profile regulation for the current phase.
    always_comb
    begin
        case (phase_reg[2:1])
            2'd0:    level_sel = level_one_reg;
            2'd1:    level_sel = level_two_reg;
            default: level_sel = level_three_reg;
        endcase
        case (phase_reg[2:1])
            2'd0:    hold_sel = TIME_BITS'(hold_one_reg);
            2'd1:    hold_sel = TIME_BITS'(hold_two_reg);
            default: hold_sel = TIME_BITS'(hold_three_reg);
        endcase
        hold_end  = hold_start_reg + hold_sel;
        phase_adv = 1'b0;
        hold_mark = 1'b0;
        relay_new = 1'b0;
        case (phase_reg)
            rsrc_pkg::PH_RAMP_ONE, rsrc_pkg::PH_RAMP_TWO, rsrc_pkg::PH_RAMP_THREE:
            begin
                if (temp_reg >= level_sel)
                begin
                    phase_adv = 1'b1;
                    hold_mark = 1'b1;
                end
                else
                begin
                    relay_new = rate_reg < $signed({1'b0, rate_limit_reg});
                end
            end
            rsrc_pkg::PH_HOLD_ONE, rsrc_pkg::PH_HOLD_TWO, rsrc_pkg::PH_HOLD_THREE:
            begin
                if (time_reg >= hold_end)
                begin
                    phase_adv = 1'b1;
                end
                else
                begin
                    relay_new = temp_reg < level_sel;
                end
            end
            rsrc_pkg::PH_COOL:
            begin
                if (temp_reg <= final_level_reg)
                begin
                    phase_adv = 1'b1;
                    hold_mark = 1'b1;
                end
                else
                begin
                    relay_new = $signed({rate_reg[15], rate_reg})
                                < -$signed({2'b00, rate_limit_reg});
                end
            end
            default:
            begin
                relay_new = 1'b0;
            end
        endcase
    end

    // Sequencer state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rsrc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequencer next state and handshake.
    always_comb
    begin
        state_next   = state_reg;
        sample_stall = 1'b1;
        unique case (state_reg)
            rsrc_pkg::ST_IDLE:
            begin
                sample_stall = 1'b0;
                if (sample_valid)
                begin
                    state_next = (sample.command == rsrc_pkg::CMD_START) ?
                                 rsrc_pkg::ST_EMIT : rsrc_pkg::ST_MUL;
                end
            end
            rsrc_pkg::ST_MUL:
            begin
                state_next = (delta_now == '0) ? rsrc_pkg::ST_REG : rsrc_pkg::ST_DIV;
            end
            rsrc_pkg::ST_DIV:
            begin
                if (count_reg == '0)
                begin
                    state_next = rsrc_pkg::ST_RATE;
                end
            end
            rsrc_pkg::ST_RATE:
            begin
                state_next = rsrc_pkg::ST_REG;
            end
            rsrc_pkg::ST_REG:
            begin
                state_next = rsrc_pkg::ST_EMIT;
            end
            rsrc_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = rsrc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rsrc_pkg::ST_IDLE;
            end
        endcase
    end

    // Item capture, multiplier and serial divider.
    always_ff @(posedge clk)
    begin
        if (sample_take)
        begin
            time_reg <= TIME_BITS'(sample.sample_time);
            temp_reg <= sample.temperature;
        end
        if (state_reg == rsrc_pkg::ST_MUL)
        begin
            delta_reg <= delta_now;
            neg_reg   <= temp_diff[16];
            mag_reg   <= 32'(diff_mag) * 32'(rsrc_pkg::MS_PER_MINUTE);
            quot_reg  <= '0;
            rem_reg   <= '0;
            count_reg <= CountBits'(rsrc_pkg::QUOT_BITS - 1);
        end
        else if (state_reg == rsrc_pkg::ST_DIV)
        begin
            rem_reg   <= rem_fits ? rem_shift - {1'b0, delta_reg} : rem_shift;
            quot_reg  <= {quot_reg[30:0], rem_fits};
            mag_reg   <= {mag_reg[30:0], 1'b0};
            count_reg <= count_reg - 1'b1;
        end
    end

    // Controller state updates.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_time_reg  <= '0;
            last_temp_reg  <= '0;
            rate_reg       <= '0;
            phase_reg      <= rsrc_pkg::PH_RAMP_ONE;
            hold_start_reg <= '0;
            relay_reg      <= 1'b0;
        end
        else
        begin
            if (sample_take && sample.command == rsrc_pkg::CMD_START)
            begin
                last_time_reg <= TIME_BITS'(sample.sample_time);
                last_temp_reg <= sample.temperature;
            end
            if (state_reg == rsrc_pkg::ST_RATE)
            begin
                rate_reg      <= rate_sat;
                last_time_reg <= time_reg;
                last_temp_reg <= temp_reg;
            end
            if (state_reg == rsrc_pkg::ST_REG)
            begin
                relay_reg <= relay_new;
                if (phase_adv)
                begin
                    phase_reg <= phase_reg + 3'd1;
                end
                if (hold_mark)
                begin
                    hold_start_reg <= time_reg;
                end
            end
        end
    end

    // Output register: valid control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (state_reg == rsrc_pkg::ST_EMIT && out_free)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    // Output register: payload.
    always_ff @(posedge clk)
    begin
        if (state_reg == rsrc_pkg::ST_EMIT && out_free)
        begin
            result_reg.relay_on  <= relay_reg;
            result_reg.phase     <= phase_reg;
            result_reg.heat_rate <= rate_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // The block takes no second item until the current one has been emitted.
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_take |=> sample_stall)
        else $error("item accepted while the previous one is in progress");

    // The profile phase only ever steps forward by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(phase_reg) |-> phase_reg == 3'($past(phase_reg) + 3'd1))
        else $error("profile phase changed by other than one step");

    // A finished profile keeps the relay off.
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == rsrc_pkg::PH_DONE |-> !relay_reg)
        else $error("relay on after the profile finished");

    // The divider remainder stays below the divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == rsrc_pkg::ST_DIV |-> rem_reg < {1'b0, delta_reg})
        else $error("divider remainder out of range");

endmodule
